@@ rtl/stl_pkg.sv @@
// shared types, constants and character helpers for the string-to-long parser
`default_nettype none

package stl_pkg;

    // fixed field widths
    localparam int CH_W     = 8;
    localparam int BASE_W   = 6;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 16;
    localparam int TDATA_W  = VALUE_W + OFFSET_W;
    localparam int TUSER_W  = 2;

    // default sizes handed to the top level
    localparam int DEF_WORD_BITS  = 64;
    localparam int DEF_COUNT_BITS = 16;

    // bases
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    // character codes
    localparam logic [CH_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CH_W-1:0] CH_CR      = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic commit;
        logic emit;
    } stl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic term;
    } stl_stat_t;

    // digit decode: bit 6 set when the character is no digit at all
    function automatic logic [BASE_W:0] digit_decode(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] v;
        logic            bad;
        v   = '0;
        bad = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = c - (CH_UPPER_A - LETTER_OFS);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = c - (CH_LOWER_A - LETTER_OFS);
        end else begin
            bad = 1'b1;
        end
        return {bad, v[BASE_W-1:0]};
    endfunction

    // whitespace: tab through carriage return, and space
    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // a base outside 2..36 becomes zero, which accepts no digit
    function automatic logic [BASE_W-1:0] valid_base(input logic [BASE_W-1:0] b);
        return (b < BASE_MIN || b > BASE_MAX) ? BASE_AUTO : b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/stl_ctrl.sv @@
// controller: accept / commit sequencing and output word handshake
`default_nettype none

module stl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output stl_pkg::stl_cmd_t      cmd,
    input  wire stl_pkg::stl_stat_t stat
);
    import stl_pkg::*;

    localparam logic C_IDLE   = 1'b0;
    localparam logic C_COMMIT = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic go;

    // output slot can take a word this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign go       = !stat.term || out_free;
    assign s_tready = (state_reg == C_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            C_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = C_COMMIT;
                end
            end
            C_COMMIT: begin
                if (go) begin
                    cmd.commit = 1'b1;
                    cmd.emit   = stat.term;
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stl_dp.sv @@
// datapath: conversion state, multiply-accumulate and result word registers
`default_nettype none

module stl_dp #(
    parameter int WORD_BITS  = stl_pkg::DEF_WORD_BITS,
    parameter int COUNT_BITS = stl_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [stl_pkg::BASE_W-1:0]    cfg_wr_data,
    input  wire logic [stl_pkg::CH_W-1:0]      s_data,
    input  wire stl_pkg::stl_cmd_t             cmd,
    output stl_pkg::stl_stat_t                 stat,
    output logic [stl_pkg::VALUE_W-1:0]        m_value,
    output logic                               m_converted,
    output logic                               m_range_error,
    output logic [stl_pkg::OFFSET_W-1:0]       m_end_offset
);
    import stl_pkg::*;

    localparam int PROD_W = WORD_BITS + BASE_W;
    localparam int EXT_W  = (COUNT_BITS > OFFSET_W) ? COUNT_BITS : OFFSET_W;
    localparam logic [PROD_W-1:0] LIM_POS = (PROD_W'(1) << (WORD_BITS - 1)) - PROD_W'(1);
    localparam logic [WORD_BITS-1:0] W_MAX = LIM_POS[WORD_BITS-1:0];
    localparam logic [WORD_BITS-1:0] W_MIN = ~W_MAX;
    localparam logic [EXT_W-1:0] OFS_SAT = EXT_W'({OFFSET_W{1'b1}});

    // conversion phases
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    // digit status
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_SOME = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    logic [BASE_W-1:0]     base_cfg_reg;
    logic [2:0]            phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [1:0]            status_reg, status_next;
    logic [BASE_W-1:0]     abase_reg, abase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [CH_W-1:0]       ch_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic [BASE_W-1:0]     first_base;
    logic [BASE_W-1:0]     mul_base;
    logic [BASE_W:0]       load_dec;
    logic [PROD_W-1:0]     prod_calc;

    logic [BASE_W:0]       dec;
    logic [BASE_W-1:0]     take_base;
    logic [PROD_W-1:0]     lim;
    logic                  take, bump, enter_first, term;

    logic [WORD_BITS-1:0]  word_val;
    logic [EXT_W-1:0]      count_ext;

    // base that the first character of a number opens with
    assign first_base = valid_base((base_cfg_reg == BASE_AUTO) ? BASE_DEC : base_cfg_reg);

    // multiply-accumulate on the incoming word
    assign load_dec  = digit_decode(s_data);
    assign mul_base  = (phase_reg == PH_SPACE || phase_reg == PH_FIRST) ? first_base : abase_reg;
    assign prod_calc = PROD_W'(acc_reg) * PROD_W'(mul_base) + PROD_W'(load_dec[BASE_W-1:0]);

    // overflow limit depends on the sign
    assign lim = LIM_POS + PROD_W'(neg_reg);

    // commit of the registered character
    always_comb begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        abase_next  = abase_reg;
        take        = 1'b0;
        bump        = 1'b0;
        enter_first = 1'b0;
        term        = 1'b0;
        take_base   = abase_reg;
        dec         = digit_decode(ch_reg);

        unique case (phase_reg)
            PH_SPACE: begin
                if (is_space(ch_reg)) begin
                    bump = 1'b1;
                end else if (ch_reg == CH_PLUS || ch_reg == CH_MINUS) begin
                    neg_next   = (ch_reg == CH_MINUS);
                    phase_next = PH_FIRST;
                    bump       = 1'b1;
                end else begin
                    enter_first = 1'b1;
                end
            end
            PH_FIRST: enter_first = 1'b1;
            PH_ZERO: begin
                if (ch_reg == CH_LOWER_X || ch_reg == CH_UPPER_X) begin
                    abase_next  = BASE_HEX;
                    status_next = ST_NONE;
                    acc_next    = '0;
                    phase_next  = PH_PREFIX;
                    bump        = 1'b1;
                end else begin
                    take = 1'b1;
                end
            end
            PH_PREFIX, PH_DIGITS: take = 1'b1;
            default: begin
                phase_next  = PH_SPACE;
                neg_next    = 1'b0;
                acc_next    = '0;
                status_next = ST_NONE;
                abase_next  = '0;
            end
        endcase

        // first character after whitespace and sign
        if (enter_first) begin
            if ((base_cfg_reg == BASE_AUTO || base_cfg_reg == BASE_HEX) && ch_reg == CH_ZERO) begin
                abase_next  = (base_cfg_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                status_next = ST_SOME;
                acc_next    = '0;
                phase_next  = PH_ZERO;
                bump        = 1'b1;
            end else begin
                abase_next = first_base;
                take_base  = first_base;
                take       = 1'b1;
            end
        end

        // digit or terminator
        if (take) begin
            if (take_base == BASE_AUTO || dec[BASE_W] || dec[BASE_W-1:0] >= take_base) begin
                term = 1'b1;
            end else begin
                if (status_reg == ST_OVER || prod_reg > lim) begin
                    status_next = ST_OVER;
                end else begin
                    status_next = ST_SOME;
                    acc_next    = prod_reg[WORD_BITS-1:0];
                end
                phase_next = PH_DIGITS;
                bump       = 1'b1;
            end
        end

        // saturating character count
        count_next = (bump && count_reg != '1) ? count_reg + COUNT_BITS'(1) : count_reg;
        if (phase_reg > PH_DIGITS) begin
            count_next = '0;
        end

        // terminator restarts the conversion
        if (term) begin
            phase_next  = PH_SPACE;
            neg_next    = 1'b0;
            acc_next    = '0;
            status_next = ST_NONE;
            abase_next  = '0;
            count_next  = '0;
        end
    end

    assign stat.term = term;

    // result fields from the state before the terminator
    always_comb begin
        if (status_reg == ST_OVER) begin
            word_val = neg_reg ? W_MIN : W_MAX;
        end else begin
            word_val = neg_reg ? ('0 - acc_reg) : acc_reg;
        end
        count_ext = (status_reg != ST_NONE) ? EXT_W'(count_reg) : '0;
    end

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cfg_reg <= BASE_RESET;
            phase_reg    <= PH_SPACE;
            neg_reg      <= 1'b0;
            acc_reg      <= '0;
            status_reg   <= ST_NONE;
            abase_reg    <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_cfg_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                acc_reg    <= acc_next;
                status_reg <= status_next;
                abase_reg  <= abase_next;
                count_reg  <= count_next;
            end
        end
    end

    // character, product and result word registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg   <= s_data;
            prod_reg <= prod_calc;
        end
        if (cmd.emit) begin
            m_value       <= VALUE_W'($signed(word_val));
            m_converted   <= (status_reg != ST_NONE);
            m_range_error <= (status_reg == ST_OVER);
            m_end_offset  <= (count_ext > OFS_SAT) ? {OFFSET_W{1'b1}}
                                                   : count_ext[OFFSET_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/string_to_long_parser_unit.sv @@
// top level of the string-to-long parser: controller plus datapath
//
//   channel   ports                      word contents
//   s_        s_tvalid/tready/tdata      [7:0] ch
//   m_        m_tvalid/tready/tdata/tuser tdata [63:0] value, [79:64] end_offset;
//                                        tuser [0] converted, [1] range_error
//   cfg       cfg_wr_en/cfg_wr_data      [5:0] number_base
//
// the accept cycle runs the accumulator times base multiply, then the commit state compares
// against the overflow limit and commits; no new character is accepted until it has committed.
// a terminator waits in the commit cycle while the output word is still held.
// reset is synchronous, active low; number_base resets to 10.
`default_nettype none

module string_to_long_parser_unit #(
    parameter int WORD_BITS  = stl_pkg::DEF_WORD_BITS,
    parameter int COUNT_BITS = stl_pkg::DEF_COUNT_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [stl_pkg::BASE_W-1:0]  cfg_wr_data,   // number_base
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [stl_pkg::CH_W-1:0]    s_tdata,       // ch
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [stl_pkg::TDATA_W-1:0]      m_tdata,       // value, end_offset
    output logic [stl_pkg::TUSER_W-1:0]      m_tuser        // converted, range_error
);
    import stl_pkg::*;

    stl_cmd_t              cmd;
    stl_stat_t             stat;
    logic [VALUE_W-1:0]    value;
    logic                  converted;
    logic                  range_error;
    logic [OFFSET_W-1:0]   end_offset;

    // sequencing
    stl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // conversion datapath
    stl_dp #(
        .WORD_BITS  (WORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_data        (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_value       (value),
        .m_converted   (converted),
        .m_range_error (range_error),
        .m_end_offset  (end_offset)
    );

    // output word packing
    assign m_tdata = {end_offset, value};
    assign m_tuser = {range_error, converted};

`ifndef SYNTH
    // an accepted word is followed by its commit cycle
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // no conversion means zero value and zero offset
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("unconverted result carries nonzero fields");

    // overflow only after digits
    a_range_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("range error without conversion");
`endif

endmodule

`default_nettype wire
